// File: sv/i2a_pkg.sv
// Shared types, constants and microcode encodings for the integer-to-ASCII converter.
package i2a_pkg;

	localparam int OPCODE_W = 2;
	localparam int VALUE_W  = 64;
	localparam int CHAR_W   = 7;
	localparam int PC_W     = 4;
	localparam int SP_W     = 4;
	localparam int STK_DEPTH = 11;

	localparam logic [OPCODE_W-1:0] OP_SDEC = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_UDEC = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_HEX  = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_PTR  = 2'd3;

	localparam logic [CHAR_W-1:0] ASC_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] ASC_X     = 7'h78;
	localparam logic [CHAR_W-1:0] ASC_MINUS = 7'h2d;
	localparam logic [CHAR_W-1:0] ASC_LC_A  = 7'h61;

	// Reciprocal of ten, scaled by 2^35.
	localparam logic [31:0] RECIP10 = 32'hcccc_cccd;
	localparam int RECIP_SHIFT = 35;

	localparam logic [SP_W-1:0] PTR_LAST_NIB = 4'd15;

	// Microcode addresses.
	localparam logic [PC_W-1:0] PC_LOAD   = 4'd0;
	localparam logic [PC_W-1:0] PC_CHKHEX = 4'd1;
	localparam logic [PC_W-1:0] PC_MUL    = 4'd2;
	localparam logic [PC_W-1:0] PC_DDIG   = 4'd3;
	localparam logic [PC_W-1:0] PC_CHKNEG = 4'd4;
	localparam logic [PC_W-1:0] PC_MINUS  = 4'd5;
	localparam logic [PC_W-1:0] PC_HDIG   = 4'd6;
	localparam logic [PC_W-1:0] PC_EMIT   = 4'd7;
	localparam logic [PC_W-1:0] PC_EDONE  = 4'd8;
	localparam logic [PC_W-1:0] PC_PTR0   = 4'd9;
	localparam logic [PC_W-1:0] PC_PTRX   = 4'd10;
	localparam logic [PC_W-1:0] PC_PTRN   = 4'd11;
	localparam logic [PC_W-1:0] PC_PDONE  = 4'd12;

	typedef enum logic [2:0] {
		DP_NOP,
		DP_LOAD,
		DP_MUL,
		DP_DDIG,
		DP_HDIG,
		DP_MINUS,
		DP_POP,
		DP_SHIFT
	} dp_op_t;

	typedef enum logic [1:0] {
		W_NONE,
		W_IN,
		W_OUT
	} wait_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_PTR,
		C_HEX,
		C_QNZ,
		C_HNZ,
		C_NOTNEG,
		C_STKMORE,
		C_PTRMORE
	} cond_t;

	typedef enum logic [1:0] {
		CH_STACK,
		CH_ZERO,
		CH_X,
		CH_NIB
	} chsel_t;

	typedef enum logic [1:0] {
		LS_NONE,
		LS_STACK,
		LS_PTR
	} lastsel_t;

	typedef struct packed {
		dp_op_t          dp;
		wait_t           wt;
		cond_t           cond;
		logic [PC_W-1:0] target;
		chsel_t          chsel;
		lastsel_t        lastsel;
	} ctrl_t;

	typedef struct packed {
		logic is_ptr;
		logic is_hex;
		logic q_nz;
		logic h_nz;
		logic not_neg;
		logic stk_more;
		logic ptr_more;
	} status_t;

	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
		logic [CHAR_W-1:0] c;
		if (nib < 4'd10) begin
			c = ASC_ZERO + {3'b000, nib};
		end else begin
			c = ASC_LC_A + {3'b000, nib - 4'd10};
		end
		return c;
	endfunction

endpackage

// File: sv/i2a_in_if.sv
// Input channel: conversion opcode and number.
interface i2a_in_if;
	logic                         valid;
	logic                         ready;
	logic [i2a_pkg::OPCODE_W-1:0] opcode;
	logic [i2a_pkg::VALUE_W-1:0]  value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink (input valid, input opcode, input value, output ready);
endinterface

// File: sv/i2a_out_if.sv
// Output channel: one ASCII character and its end-of-number mark.
interface i2a_out_if;
	logic                       valid;
	logic                       ready;
	logic [i2a_pkg::CHAR_W-1:0] char_out;
	logic                       last;

	modport source (output valid, output char_out, output last, input ready);
	modport sink (input valid, input char_out, input last, output ready);
endinterface

// File: sv/i2a_ucode_rom.sv
// Microcode program store: one control word per sequencer step.
module i2a_ucode_rom (
	input  logic [i2a_pkg::PC_W-1:0] pc,
	output i2a_pkg::ctrl_t           ctrl
);

	always_comb begin
		ctrl = '{dp: i2a_pkg::DP_NOP, wt: i2a_pkg::W_NONE, cond: i2a_pkg::C_ALWAYS,
			target: i2a_pkg::PC_LOAD, chsel: i2a_pkg::CH_STACK,
			lastsel: i2a_pkg::LS_NONE};
		case (pc)
			i2a_pkg::PC_LOAD: begin
				ctrl.dp = i2a_pkg::DP_LOAD;
				ctrl.wt = i2a_pkg::W_IN;
				ctrl.cond = i2a_pkg::C_PTR;
				ctrl.target = i2a_pkg::PC_PTR0;
			end
			i2a_pkg::PC_CHKHEX: begin
				ctrl.cond = i2a_pkg::C_HEX;
				ctrl.target = i2a_pkg::PC_HDIG;
			end
			i2a_pkg::PC_MUL: begin
				ctrl.dp = i2a_pkg::DP_MUL;
				ctrl.cond = i2a_pkg::C_NEVER;
			end
			i2a_pkg::PC_DDIG: begin
				ctrl.dp = i2a_pkg::DP_DDIG;
				ctrl.cond = i2a_pkg::C_QNZ;
				ctrl.target = i2a_pkg::PC_MUL;
			end
			i2a_pkg::PC_CHKNEG: begin
				ctrl.cond = i2a_pkg::C_NOTNEG;
				ctrl.target = i2a_pkg::PC_EMIT;
			end
			i2a_pkg::PC_MINUS: begin
				ctrl.dp = i2a_pkg::DP_MINUS;
				ctrl.target = i2a_pkg::PC_EMIT;
			end
			i2a_pkg::PC_HDIG: begin
				ctrl.dp = i2a_pkg::DP_HDIG;
				ctrl.cond = i2a_pkg::C_HNZ;
				ctrl.target = i2a_pkg::PC_HDIG;
			end
			i2a_pkg::PC_EMIT: begin
				ctrl.dp = i2a_pkg::DP_POP;
				ctrl.wt = i2a_pkg::W_OUT;
				ctrl.cond = i2a_pkg::C_STKMORE;
				ctrl.target = i2a_pkg::PC_EMIT;
				ctrl.chsel = i2a_pkg::CH_STACK;
				ctrl.lastsel = i2a_pkg::LS_STACK;
			end
			i2a_pkg::PC_EDONE: begin
				ctrl.target = i2a_pkg::PC_LOAD;
			end
			i2a_pkg::PC_PTR0: begin
				ctrl.wt = i2a_pkg::W_OUT;
				ctrl.cond = i2a_pkg::C_NEVER;
				ctrl.chsel = i2a_pkg::CH_ZERO;
			end
			i2a_pkg::PC_PTRX: begin
				ctrl.wt = i2a_pkg::W_OUT;
				ctrl.cond = i2a_pkg::C_NEVER;
				ctrl.chsel = i2a_pkg::CH_X;
			end
			i2a_pkg::PC_PTRN: begin
				ctrl.dp = i2a_pkg::DP_SHIFT;
				ctrl.wt = i2a_pkg::W_OUT;
				ctrl.cond = i2a_pkg::C_PTRMORE;
				ctrl.target = i2a_pkg::PC_PTRN;
				ctrl.chsel = i2a_pkg::CH_NIB;
				ctrl.lastsel = i2a_pkg::LS_PTR;
			end
			i2a_pkg::PC_PDONE: begin
				ctrl.target = i2a_pkg::PC_LOAD;
			end
			default: begin
				ctrl.target = i2a_pkg::PC_LOAD;
			end
		endcase
	end

endmodule

// File: sv/i2a_datapath.sv
// Conversion datapath: number register, reciprocal multiplier, digit stack, output select.
module i2a_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  i2a_pkg::ctrl_t                   ctrl,
	input  logic                             fire,
	input  logic [i2a_pkg::OPCODE_W-1:0]     opcode,
	input  logic [i2a_pkg::VALUE_W-1:0]      value,
	output logic [i2a_pkg::CHAR_W-1:0]       char_out,
	output logic                             last,
	output i2a_pkg::status_t                 status
);

	logic [i2a_pkg::VALUE_W-1:0] x_q;
	logic [63:0]                 prod_q;
	logic                        neg_q;
	logic [i2a_pkg::OPCODE_W-1:0] op_q;
	logic [i2a_pkg::SP_W-1:0]    sp_q;
	logic [i2a_pkg::CHAR_W-1:0]  stk_q [i2a_pkg::STK_DEPTH];

	logic [28:0]                 quot;
	logic [31:0]                 rem;
	logic [31:0]                 mag;
	logic                        in_neg;
	logic [i2a_pkg::SP_W-1:0]    top_idx;
	logic [i2a_pkg::CHAR_W-1:0]  push_char;
	logic                        push;

	assign quot    = prod_q[63:i2a_pkg::RECIP_SHIFT];
	assign rem     = x_q[31:0] - {quot, 3'b000} - {2'b00, quot, 1'b0};
	assign in_neg  = (opcode == i2a_pkg::OP_SDEC) && value[31];
	assign mag     = in_neg ? (32'd0 - value[31:0]) : value[31:0];
	assign top_idx = sp_q - 4'd1;

	always_comb begin
		push      = 1'b0;
		push_char = i2a_pkg::ASC_MINUS;
		case (ctrl.dp)
			i2a_pkg::DP_DDIG: begin
				push      = 1'b1;
				push_char = i2a_pkg::ASC_ZERO + {3'b000, rem[3:0]};
			end
			i2a_pkg::DP_HDIG: begin
				push      = 1'b1;
				push_char = i2a_pkg::hex_char(x_q[3:0]);
			end
			i2a_pkg::DP_MINUS: begin
				push      = 1'b1;
				push_char = i2a_pkg::ASC_MINUS;
			end
			default: begin
				push      = 1'b0;
				push_char = i2a_pkg::ASC_MINUS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q  <= '0;
			neg_q <= 1'b0;
			op_q  <= i2a_pkg::OP_SDEC;
		end else if (fire) begin
			case (ctrl.dp)
				i2a_pkg::DP_LOAD: begin
					sp_q  <= '0;
					neg_q <= in_neg;
					op_q  <= opcode;
				end
				i2a_pkg::DP_DDIG, i2a_pkg::DP_HDIG, i2a_pkg::DP_MINUS,
				i2a_pkg::DP_SHIFT: begin
					sp_q <= sp_q + 4'd1;
				end
				i2a_pkg::DP_POP: begin
					sp_q <= top_idx;
				end
				default: begin
					sp_q <= sp_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			case (ctrl.dp)
				i2a_pkg::DP_LOAD: begin
					x_q <= (opcode == i2a_pkg::OP_PTR) ? value : {32'd0, mag};
				end
				i2a_pkg::DP_MUL: begin
					prod_q <= x_q[31:0] * i2a_pkg::RECIP10;
				end
				i2a_pkg::DP_DDIG: begin
					x_q <= {35'd0, quot};
				end
				i2a_pkg::DP_HDIG: begin
					x_q <= {4'd0, x_q[63:4]};
				end
				i2a_pkg::DP_SHIFT: begin
					x_q <= {x_q[59:0], 4'd0};
				end
				default: begin
					x_q <= x_q;
				end
			endcase
			if (push) begin
				stk_q[sp_q] <= push_char;
			end
		end
	end

	always_comb begin
		case (ctrl.chsel)
			i2a_pkg::CH_STACK: char_out = stk_q[top_idx];
			i2a_pkg::CH_ZERO:  char_out = i2a_pkg::ASC_ZERO;
			i2a_pkg::CH_X:     char_out = i2a_pkg::ASC_X;
			i2a_pkg::CH_NIB:   char_out = i2a_pkg::hex_char(x_q[63:60]);
			default:           char_out = i2a_pkg::ASC_ZERO;
		endcase
		case (ctrl.lastsel)
			i2a_pkg::LS_STACK: last = (sp_q == 4'd1);
			i2a_pkg::LS_PTR:   last = (sp_q == i2a_pkg::PTR_LAST_NIB);
			default:           last = 1'b0;
		endcase
	end

	assign status.is_ptr   = (opcode == i2a_pkg::OP_PTR);
	assign status.is_hex   = (op_q == i2a_pkg::OP_HEX);
	assign status.q_nz     = (quot != 29'd0);
	assign status.h_nz     = (x_q[31:4] != 28'd0);
	assign status.not_neg  = !neg_q;
	assign status.stk_more = (sp_q != 4'd1);
	assign status.ptr_more = (sp_q != i2a_pkg::PTR_LAST_NIB);

	a_stack_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.chsel == i2a_pkg::CH_STACK && ctrl.wt == i2a_pkg::W_OUT) |-> (sp_q != 4'd0))
		else $error("stack read while empty");

	a_push_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && push) |-> (sp_q < 4'(i2a_pkg::STK_DEPTH)))
		else $error("stack overflow");

endmodule

// File: sv/integer_to_ascii_digits.sv
// Top level: microcode sequencer driving the integer-to-ASCII datapath.
// Takes one item (opcode, 64-bit value) and returns its ASCII characters most
// significant first, last set on the final one; a new item is taken only after
// the previous one's characters are all delivered. Signed and unsigned decimal
// extract in a load, a hex check, one reciprocal multiply and one remainder step
// per digit, and a sign check, plus one step for a minus sign; then an output
// step per character and a closing step. Hex extracts in a load, a hex check
// and one step per digit, then an output step per character and a closing step.
// Pointer emits its 18 characters, "0x" and 16 nibbles, then a closing step.
// Output stalls simply stretch the per-character steps.
module integer_to_ascii_digits (
	input  logic      clk,
	input  logic      arst_n,
	i2a_in_if.sink    in_ch,
	i2a_out_if.source out_ch
);

	logic [i2a_pkg::PC_W-1:0] pc_q;
	i2a_pkg::ctrl_t           ctrl;
	i2a_pkg::status_t         status;
	logic                     fire;
	logic                     take;

	i2a_ucode_rom u_rom (
		.pc   (pc_q),
		.ctrl (ctrl)
	);

	i2a_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.fire     (fire),
		.opcode   (in_ch.opcode),
		.value    (in_ch.value),
		.char_out (out_ch.char_out),
		.last     (out_ch.last),
		.status   (status)
	);

	assign in_ch.ready  = (ctrl.wt == i2a_pkg::W_IN);
	assign out_ch.valid = (ctrl.wt == i2a_pkg::W_OUT);

	always_comb begin
		case (ctrl.wt)
			i2a_pkg::W_IN:  fire = in_ch.valid;
			i2a_pkg::W_OUT: fire = out_ch.ready;
			default:        fire = 1'b1;
		endcase
		case (ctrl.cond)
			i2a_pkg::C_ALWAYS:  take = 1'b1;
			i2a_pkg::C_PTR:     take = status.is_ptr;
			i2a_pkg::C_HEX:     take = status.is_hex;
			i2a_pkg::C_QNZ:     take = status.q_nz;
			i2a_pkg::C_HNZ:     take = status.h_nz;
			i2a_pkg::C_NOTNEG:  take = status.not_neg;
			i2a_pkg::C_STKMORE: take = status.stk_more;
			i2a_pkg::C_PTRMORE: take = status.ptr_more;
			default:            take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= i2a_pkg::PC_LOAD;
		end else if (fire) begin
			pc_q <= take ? ctrl.target : pc_q + 4'd1;
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready)
		else $error("input ready while characters pending");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("second item taken back to back");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && out_ch.last) |=> !out_ch.valid)
		else $error("character after last");

	a_not_last_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && !out_ch.last) |=> out_ch.valid)
		else $error("number ended without last");

endmodule

// File: bench/tb_integer_to_ascii_digits.sv
// Self-checking testbench for the integer-to-ASCII digit converter.
`timescale 1ns / 1ps

module tb_integer_to_ascii_digits;

	localparam int RANDOM_ITEMS = 306;
	localparam int DIRECTED_ITEMS = 24;
	localparam int TOTAL_ITEMS = DIRECTED_ITEMS + RANDOM_ITEMS;
	localparam int CALM_ITEMS = 40;
	localparam int HOLD_OFF_AT = 60;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT = 1000000;
	localparam string HEX_DIGITS = "0123456789abcdef";

	typedef struct packed {
		logic [i2a_pkg::CHAR_W-1:0] ch;
		logic                       last;
	} char_rec_t;

	typedef struct {
		logic [i2a_pkg::OPCODE_W-1:0] op;
		logic [i2a_pkg::VALUE_W-1:0]  value;
		string                        text;
	} number_row_t;

	logic clk;
	logic arst_n;

	i2a_in_if  in_ch();
	i2a_out_if out_ch();

	char_rec_t pending_chars[$];
	int        errors;
	int        sent;
	bit        calm;

	number_row_t number_rows[DIRECTED_ITEMS] = '{
		'{i2a_pkg::OP_SDEC, 64'h0, "0"},
		'{i2a_pkg::OP_UDEC, 64'h0, "0"},
		'{i2a_pkg::OP_HEX,  64'h0, "0"},
		'{i2a_pkg::OP_PTR,  64'h0, "0x0000000000000000"},
		'{i2a_pkg::OP_PTR,  64'hffff_ffff_ffff_ffff, "0xffffffffffffffff"},
		'{i2a_pkg::OP_SDEC, 64'h0000_0000_8000_0000, "-2147483648"},
		'{i2a_pkg::OP_SDEC, 64'h0000_0000_7fff_ffff, "2147483647"},
		'{i2a_pkg::OP_SDEC, 64'h0000_0000_ffff_ffff, "-1"},
		'{i2a_pkg::OP_UDEC, 64'h0000_0000_ffff_ffff, "4294967295"},
		'{i2a_pkg::OP_HEX,  64'h0000_0000_ffff_ffff, "ffffffff"},
		'{i2a_pkg::OP_SDEC, 64'hffff_ffff_0000_0005, "5"},
		'{i2a_pkg::OP_UDEC, 64'hdead_beef_8000_0000, "2147483648"},
		'{i2a_pkg::OP_HEX,  64'h1234_5678_0000_abcd, "abcd"},
		'{i2a_pkg::OP_PTR,  64'h0123_4567_89ab_cdef, "0x0123456789abcdef"},
		'{i2a_pkg::OP_SDEC, 64'd9, "9"},
		'{i2a_pkg::OP_UDEC, 64'd10, "10"},
		'{i2a_pkg::OP_HEX,  64'd15, "f"},
		'{i2a_pkg::OP_HEX,  64'd16, "10"},
		'{i2a_pkg::OP_SDEC, 64'd1000000000, ""},
		'{i2a_pkg::OP_UDEC, 64'hffff_0000_ee6b_27ff, ""},
		'{i2a_pkg::OP_SDEC, 64'h0000_0000_ffff_fff6, "-10"},
		'{i2a_pkg::OP_HEX,  64'h0000_0000_8000_0000, "80000000"},
		'{i2a_pkg::OP_PTR,  64'hfedc_ba98_7654_3210, "0xfedcba9876543210"},
		'{i2a_pkg::OP_SDEC, 64'h5555_aaaa_8000_0001, ""}
	};

	integer_to_ascii_digits uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	function automatic logic [i2a_pkg::CHAR_W-1:0] nibble_char(input logic [3:0] nib);
		logic [7:0] b;
		b = HEX_DIGITS[nib];
		return b[i2a_pkg::CHAR_W-1:0];
	endfunction

	function automatic void predict_chars(input logic [i2a_pkg::OPCODE_W-1:0] op,
			input logic [i2a_pkg::VALUE_W-1:0] value);
		logic [i2a_pkg::CHAR_W-1:0] text[$];
		logic [31:0]                mag;
		bit                         neg;
		text = {};
		if (op == i2a_pkg::OP_PTR) begin
			text.push_back(i2a_pkg::ASC_ZERO);
			text.push_back(i2a_pkg::ASC_X);
			for (int i = 15; i >= 0; i--) begin
				text.push_back(nibble_char(value[4*i +: 4]));
			end
		end else begin
			mag = value[31:0];
			neg = (op == i2a_pkg::OP_SDEC) && mag[31];
			if (neg) begin
				mag = -mag;
			end
			if (op == i2a_pkg::OP_HEX) begin
				do begin
					text.push_front(nibble_char(mag[3:0]));
					mag = mag >> 4;
				end while (mag != 0);
			end else begin
				do begin
					text.push_front(i2a_pkg::ASC_ZERO + i2a_pkg::CHAR_W'(mag % 10));
					mag = mag / 10;
				end while (mag != 0);
			end
			if (neg) begin
				text.push_front(i2a_pkg::ASC_MINUS);
			end
		end
		foreach (text[i]) begin
			pending_chars.push_back('{ch: text[i], last: (i == text.size() - 1)});
		end
	endfunction

	function automatic logic [i2a_pkg::VALUE_W-1:0] pick_value();
		logic [i2a_pkg::VALUE_W-1:0] v;
		logic [31:0]                 p10;
		int                          k;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: begin
				v = v >> $urandom_range(0, 63);
			end
			1: begin
				v[31:0] = $urandom_range(0, 20);
			end
			2: begin
				p10 = 1;
				k = $urandom_range(0, 9);
				repeat (k) p10 = p10 * 10;
				v[31:0] = p10 + $urandom_range(0, 2) - 1;
			end
			3: begin
				v[31:0] = 32'h8000_0000 + $urandom_range(0, 2) - 1;
			end
			4: begin
				v[31:0] = 32'hffff_ffff - $urandom_range(0, 9);
			end
			default: begin
			end
		endcase
		return v;
	endfunction

	task automatic send_number(input logic [i2a_pkg::OPCODE_W-1:0] op,
			input logic [i2a_pkg::VALUE_W-1:0] value, input string text);
		logic [7:0] b;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_ch.valid = 1'b0;
			in_ch.opcode = i2a_pkg::OPCODE_W'($urandom_range(0, 3));
			in_ch.value = {$urandom, $urandom};
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.opcode = op;
		in_ch.value = value;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		if (text.len() == 0) begin
			predict_chars(op, value);
		end else begin
			for (int i = 0; i < text.len(); i++) begin
				b = text[i];
				pending_chars.push_back('{ch: b[i2a_pkg::CHAR_W-1:0],
					last: (i == text.len() - 1)});
			end
		end
		sent++;
		calm = (sent >= TOTAL_ITEMS - CALM_ITEMS);
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.opcode = i2a_pkg::OP_SDEC;
		in_ch.value = '0;
		errors = 0;
		sent = 0;
		calm = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		foreach (number_rows[i]) begin
			send_number(number_rows[i].op, number_rows[i].value, number_rows[i].text);
		end
		repeat (RANDOM_ITEMS) begin
			send_number(i2a_pkg::OPCODE_W'($urandom_range(0, 3)), pick_value(), "");
		end
		in_ch.valid = 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		bit held;
		held = 1'b0;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!held && sent >= HOLD_OFF_AT) begin
				held = 1'b1;
				out_ch.ready = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ch.ready = 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end else begin
				out_ch.ready = 1'b1;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin : check_chars
		char_rec_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_chars.size() == 0) begin
				$error("char_out unexpected: expected none, got %h", out_ch.char_out);
				errors++;
			end else begin
				want = pending_chars.pop_front();
				if (out_ch.char_out !== want.ch) begin
					$error("char_out mismatch: expected %h, got %h", want.ch, out_ch.char_out);
					errors++;
				end
				if (out_ch.last !== want.last) begin
					$error("last mismatch: expected %b, got %b", want.last, out_ch.last);
					errors++;
				end
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
